/* src/ipsv_pkg.sv */
// ----------------------------------------------------------------------------
// ipsv_pkg
// Types and constants for the IPv4 address and port text parser.
// ----------------------------------------------------------------------------
package ipsv_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned OUT_W   = 56;

    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [2:0]  OCTETS    = 3'd4;
    localparam logic [8:0]  OCTET_MAX = 9'd255;
    localparam logic [8:0]  OCTET_CAP = 9'd256;
    localparam logic [16:0] PORT_MAX  = 17'd65535;
    localparam logic [16:0] PORT_CAP  = 17'd65536;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_CHAR  = 3'd1,
        ERR_OCTET = 3'd2,
        ERR_COUNT = 3'd3,
        ERR_PORT  = 3'd4
    } t_err;

    typedef enum logic {
        PH_ADDR = 1'b0,
        PH_PORT = 1'b1
    } t_phase;

    typedef struct packed {
        t_phase        phase;
        logic [8:0]    octet_value;
        logic          octet_has_digit;
        logic          octet_starts_zero;
        logic [2:0]    octet_count;
        logic [31:0]   address_shift;
        logic [16:0]   port_value;
        logic          port_has_digit;
        t_err          first_error;
    } t_parse_st;

    localparam t_parse_st ST_RESET = '{
        phase:             PH_ADDR,
        octet_value:       9'd0,
        octet_has_digit:   1'b0,
        octet_starts_zero: 1'b0,
        octet_count:       3'd0,
        address_shift:     32'd0,
        port_value:        17'd0,
        port_has_digit:    1'b0,
        first_error:       ERR_NONE
    };

    typedef struct packed {
        logic          valid_res;
        logic [31:0]   ipv4_address;
        logic [15:0]   port_val;
        t_err          error_kind;
    } t_result;

endpackage

/* src/ipsv_step.sv */
// ----------------------------------------------------------------------------
// ipsv_step
// One character step of the parser: next parse state and end-of-text result.
// ----------------------------------------------------------------------------
module ipsv_step (
    input  ipsv_pkg::t_parse_st i_st,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    output ipsv_pkg::t_parse_st o_st_next,
    output ipsv_pkg::t_result   o_res
);
    import ipsv_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] oct_acc;
    logic [19:0] port_acc;
    logic        close_ok;
    t_parse_st   st_close;
    t_parse_st   st_chr;
    t_err        fin_err;
    logic        ok;

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign digit    = is_digit ? 4'(i_ch - CH_ZERO) : 4'd0;
    assign oct_acc  = 12'(i_st.octet_value) * 12'd10 + 12'(digit);
    assign port_acc = 20'(i_st.port_value) * 20'd10 + 20'(digit);

    // octet close on '.' or ':'
    always_comb begin
        st_close = i_st;
        close_ok = 1'b0;
        if (!i_st.octet_has_digit || i_st.octet_value > OCTET_MAX) begin
            st_close.first_error = ERR_OCTET;
        end else if (i_st.octet_count >= OCTETS) begin
            st_close.first_error = ERR_COUNT;
        end else begin
            close_ok                   = 1'b1;
            st_close.octet_count       = i_st.octet_count + 3'd1;
            st_close.address_shift     = {i_st.address_shift[23:0], i_st.octet_value[7:0]};
            st_close.octet_value       = 9'd0;
            st_close.octet_has_digit   = 1'b0;
            st_close.octet_starts_zero = 1'b0;
        end
    end

    always_comb begin
        st_chr = i_st;
        if (i_st.first_error == ERR_NONE) begin
            unique case (i_st.phase)
                PH_ADDR: begin
                    if (is_digit) begin
                        if (i_st.octet_has_digit && i_st.octet_starts_zero) begin
                            st_chr.first_error = ERR_OCTET;
                        end else begin
                            if (!i_st.octet_has_digit) begin
                                st_chr.octet_starts_zero = (digit == 4'd0);
                            end
                            st_chr.octet_has_digit = 1'b1;
                            st_chr.octet_value = (oct_acc > 12'(OCTET_CAP)) ?
                                                 OCTET_CAP : oct_acc[8:0];
                        end
                    end else if (i_ch == CH_DOT) begin
                        st_chr = st_close;
                    end else if (i_ch == CH_COLON) begin
                        st_chr = st_close;
                        if (close_ok) begin
                            if (st_close.octet_count != OCTETS) begin
                                st_chr.first_error = ERR_COUNT;
                            end else begin
                                st_chr.phase = PH_PORT;
                            end
                        end
                    end else begin
                        st_chr.first_error = ERR_CHAR;
                    end
                end
                PH_PORT: begin
                    if (is_digit) begin
                        if (!i_st.port_has_digit && digit == 4'd0) begin
                            st_chr.first_error = ERR_PORT;
                        end else begin
                            st_chr.port_has_digit = 1'b1;
                            st_chr.port_value = (port_acc > 20'(PORT_CAP)) ?
                                                PORT_CAP : port_acc[16:0];
                        end
                    end else if (i_ch == CH_DOT || i_ch == CH_COLON) begin
                        st_chr.first_error = ERR_PORT;
                    end else begin
                        st_chr.first_error = ERR_CHAR;
                    end
                end
                default: st_chr = i_st;
            endcase
        end
    end

    always_comb begin
        fin_err = st_chr.first_error;
        if (fin_err == ERR_NONE && (st_chr.phase != PH_PORT || !st_chr.port_has_digit
                                    || st_chr.port_value > PORT_MAX)) begin
            fin_err = ERR_PORT;
        end
    end

    assign ok                 = (fin_err == ERR_NONE);
    assign o_res.valid_res    = ok;
    assign o_res.ipv4_address = ok ? st_chr.address_shift : 32'd0;
    assign o_res.port_val     = ok ? st_chr.port_value[15:0] : 16'd0;
    assign o_res.error_kind   = fin_err;
    assign o_st_next          = i_last ? ST_RESET : st_chr;

endmodule

/* src/ipv4_port_string_validator.sv */
// ----------------------------------------------------------------------------
// ipv4_port_string_validator
// Parses "a.b.c.d:port" text, one character per word, into address and port.
// ----------------------------------------------------------------------------
// Takes one character per clock while no final character is held back. A
// character passes an input register, then a single parse step updates the
// running state; the word carrying tlast produces one result word in the
// output register, and the parser is back at its start state for the next
// text when that result is registered. A result waiting in the output
// register stalls only a final character behind it; other characters keep flowing.
module ipv4_port_string_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // [0] valid_res, [32:1] ipv4_address,
                                       // [48:33] port, [51:49] error_kind,
                                       // [55:52] zero
);
    import ipsv_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_ch;
    logic        r_in_last;
    t_parse_st   r_st;
    t_parse_st   n_st;
    t_result     n_res;
    t_result     r_res;
    logic        r_out_vld;
    logic        consume;

    assign consume = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || consume;

    ipsv_step u_step (
        .i_st      (r_st),
        .i_ch      (r_in_ch),
        .i_last    (r_in_last),
        .o_st_next (n_st),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= ST_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (consume) begin
                r_st <= n_st;
            end
            if (consume && r_in_last) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (consume && r_in_last) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_res.error_kind, r_res.port_val,
                            r_res.ipv4_address, r_res.valid_res};

    a_valid_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.valid_res) |-> (r_res.error_kind == ERR_NONE))
        else $error("valid result with error code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_res.valid_res) |->
        (r_res.ipv4_address == 32'd0 && r_res.port_val == 16'd0
         && r_res.error_kind != ERR_NONE))
        else $error("invalid result carries payload");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_last) |=> (r_st == ST_RESET))
        else $error("parser not restarted after final character");

    a_port_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_PORT) |-> (r_st.octet_count == OCTETS))
        else $error("port phase entered without four octets");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_res)))
        else $error("pending result overwritten");

endmodule

/* verif/ipv4_port_string_checker.sv */
// ----------------------------------------------------------------------------
// ipv4_port_string_checker
// Watches both stream ports of the address/port parser. It runs its own copy
// of the parse state over every accepted character, queues the result each
// text should produce, and compares every output word against the oldest one.
// ----------------------------------------------------------------------------
module ipv4_port_string_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // [0] valid_res, [32:1] ipv4_address,
                                     // [48:33] port, [51:49] error_kind
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results,
    output int          o_well_formed
);
    import ipsv_pkg::*;

    t_parse_st parse_st;
    t_result   expected_parses[$];
    t_result   want;
    t_result   seen;
    int        mismatches;
    int        results;
    int        well_formed;

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 results, what, exp_v, got_v);
        mismatches++;
    endtask

    task automatic note_error(input t_err kind);
        if (parse_st.first_error == ERR_NONE) begin
            parse_st.first_error = kind;
        end
    endtask

    task automatic close_octet(output bit ok);
        ok = 1'b0;
        if (!parse_st.octet_has_digit || parse_st.octet_value > OCTET_MAX) begin
            note_error(ERR_OCTET);
        end else if (parse_st.octet_count >= OCTETS) begin
            note_error(ERR_COUNT);
        end else begin
            parse_st.octet_count       = parse_st.octet_count + 3'd1;
            parse_st.address_shift     = {parse_st.address_shift[23:0],
                                          parse_st.octet_value[7:0]};
            parse_st.octet_value       = '0;
            parse_st.octet_has_digit   = 1'b0;
            parse_st.octet_starts_zero = 1'b0;
            ok = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        bit is_digit;
        bit ok;
        int d;
        int v;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = is_digit ? int'(c - CH_ZERO) : 0;
        if (parse_st.phase == PH_ADDR) begin
            if (is_digit) begin
                if (parse_st.octet_has_digit && parse_st.octet_starts_zero) begin
                    note_error(ERR_OCTET);
                    return;
                end
                if (!parse_st.octet_has_digit) begin
                    parse_st.octet_starts_zero = (d == 0);
                end
                parse_st.octet_has_digit = 1'b1;
                v = int'(parse_st.octet_value) * 10 + d;
                if (v > int'(OCTET_CAP)) begin
                    v = int'(OCTET_CAP);
                end
                parse_st.octet_value = v[8:0];
            end else if (c == CH_DOT) begin
                close_octet(ok);
            end else if (c == CH_COLON) begin
                close_octet(ok);
                if (!ok) begin
                    return;
                end
                if (parse_st.octet_count != OCTETS) begin
                    note_error(ERR_COUNT);
                    return;
                end
                parse_st.phase = PH_PORT;
            end else begin
                note_error(ERR_CHAR);
            end
        end else begin
            if (is_digit) begin
                if (!parse_st.port_has_digit && d == 0) begin
                    note_error(ERR_PORT);
                    return;
                end
                parse_st.port_has_digit = 1'b1;
                v = int'(parse_st.port_value) * 10 + d;
                if (v > int'(PORT_CAP)) begin
                    v = int'(PORT_CAP);
                end
                parse_st.port_value = v[16:0];
            end else if (c == CH_DOT || c == CH_COLON) begin
                note_error(ERR_PORT);
            end else begin
                note_error(ERR_CHAR);
            end
        end
    endtask

    // end of text: final checks, queue the result, start clean
    task automatic finish_text();
        bit ok;
        if (parse_st.phase != PH_PORT) begin
            note_error(ERR_PORT);
        end else if (!parse_st.port_has_digit || parse_st.port_value > PORT_MAX) begin
            note_error(ERR_PORT);
        end
        ok = (parse_st.first_error == ERR_NONE);
        want.valid_res    = ok;
        want.ipv4_address = ok ? parse_st.address_shift : 32'd0;
        want.port_val     = ok ? parse_st.port_value[15:0] : 16'd0;
        want.error_kind   = parse_st.first_error;
        expected_parses.push_back(want);
        parse_st = ST_RESET;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_st = ST_RESET;
            expected_parses.delete();
            mismatches  = 0;
            results     = 0;
            well_formed = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (parse_st.first_error == ERR_NONE) begin
                    parse_char(i_s_tdata);
                end
                if (i_s_tlast) begin
                    finish_text();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.valid_res    = i_m_tdata[0];
                seen.ipv4_address = i_m_tdata[32:1];
                seen.port_val     = i_m_tdata[48:33];
                seen.error_kind   = t_err'(i_m_tdata[51:49]);
                if (expected_parses.size() == 0) begin
                    report_mismatch("unexpected word", 0, i_m_tdata);
                end else begin
                    want = expected_parses.pop_front();
                    if (seen.valid_res !== want.valid_res)
                        report_mismatch("valid_res", want.valid_res, seen.valid_res);
                    if (seen.ipv4_address !== want.ipv4_address)
                        report_mismatch("ipv4_address", want.ipv4_address,
                                        seen.ipv4_address);
                    if (seen.port_val !== want.port_val)
                        report_mismatch("port", want.port_val, seen.port_val);
                    if (seen.error_kind !== want.error_kind)
                        report_mismatch("error_kind", want.error_kind, seen.error_kind);
                    if (want.valid_res) begin
                        well_formed++;
                    end
                end
                results++;
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= expected_parses.size();
        o_results     <= results;
        o_well_formed <= well_formed;
    end

endmodule

/* verif/tb_ipv4_port_string_validator.sv */
// ----------------------------------------------------------------------------
// tb_ipv4_port_string_validator
// Regression for the IPv4 address/port text parser. Sends a set of directed
// texts covering each error kind and the field extremes, then random texts:
// mostly well-formed addresses, some with one character corrupted, some pure
// noise. Random gaps on the input and random stalls on the output; a separate
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ipv4_port_string_validator;
    import ipsv_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CHAR_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    int   mismatches;
    int   pending;
    int   results;
    int   well_formed;
    int   cycle_count = 0;
    int   ready_hold  = 0;
    bit   steady      = 1'b0;
    int   chars_sent  = 0;
    int   texts_sent  = 0;
    logic [7:0] text_buf[$];

    string directed_texts [0:22] = '{
        "0.0.0.0:1", "255.255.255.255:65535", "1.2.3.4:65536", "1.2.3.4:0",
        "1.2.3.4:", "1.2.3.4", ".1.2.3:5", "1..2.3:5", "1.2.3.:5", ":80",
        "01.2.3.4:5", "256.1.1.1:5", "9999.1.1.1:5", "1.2.3.4.5:6", "1.2.3:4",
        "1.2.3.4:5.6", "1.2.3.4:5:6", "1.a.3.4:5", "1.2.3.4:5x",
        "1.2.3.4:99999999", "1x..::0", "7", "10.20.30.40:8080"
    };

    ipv4_port_string_validator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ipv4_port_string_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results),
        .o_well_formed (well_formed)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ipv4_port_string_validator regression: fail");
            $finish;
        end
    end

    // output backpressure: short ready runs, short stalls, an occasional long one
    always @(posedge i_clk) begin
        if (steady) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
        end
    end

    function automatic int gap_cycles();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // half the time a text character, otherwise any byte
    function automatic logic [7:0] pick_char();
        int r;
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 11);
        if (r == 10) begin
            return CH_DOT;
        end
        if (r == 11) begin
            return CH_COLON;
        end
        return CH_ZERO + 8'(r);
    endfunction

    function automatic int pick_octet();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_port();
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return 65535;
            2:       return $urandom_range(1, 999);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic make_address_text();
        text_buf.delete();
        for (int i = 0; i < 4; i++) begin
            if (i != 0) begin
                text_buf.push_back(CH_DOT);
            end
            put_str($sformatf("%0d", pick_octet()));
        end
        text_buf.push_back(CH_COLON);
        put_str($sformatf("%0d", pick_port()));
    endtask

    task automatic corrupt_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf[pos] = pick_char();
            1: text_buf.insert(pos, pick_char());
            2: if (text_buf.size() > 1) text_buf.delete(pos);
            3: text_buf.push_back(pick_char());
            default: text_buf.insert(pos, CH_ZERO);
        endcase
    endtask

    task automatic make_noise_text();
        int n;
        n = $urandom_range(1, 12);
        text_buf.delete();
        repeat (n) text_buf.push_back(pick_char());
    endtask

    // one word per character, tlast on the final one
    task automatic send_text();
        int gap;
        for (int i = 0; i < text_buf.size(); i++) begin
            gap = gap_cycles();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_buf[i];
            s_axis_tlast  <= (i == text_buf.size() - 1);
            do @(posedge i_clk); while (!s_axis_tready);
        end
        chars_sent += text_buf.size();
        texts_sent++;
    endtask

    initial begin
        int kind;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_texts[k]) begin
            text_buf.delete();
            put_str(directed_texts[k]);
            send_text();
        end
        // top bit set: '9' | 0x80 in the port, 0xFF in an octet
        text_buf.delete();
        put_str("1.2.3.4:");
        text_buf.push_back(8'hB9);
        send_text();
        text_buf.delete();
        put_str("1.");
        text_buf.push_back(8'hFF);
        put_str(".3.4:5");
        send_text();

        while (chars_sent < CHAR_TARGET) begin
            steady <= ((texts_sent % 40) >= 32);
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                make_address_text();
            end else if (kind < 85) begin
                make_address_text();
                corrupt_text();
            end else begin
                make_noise_text();
            end
            send_text();
        end
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d texts (%0d characters) with random gaps and output stalls",
                 texts_sent, chars_sent);
        $display("checked %0d result words, %0d well-formed, %0d mismatches",
                 results, well_formed, mismatches);
        if (mismatches == 0) begin
            $display("ipv4_port_string_validator regression: pass");
        end else begin
            $display("ipv4_port_string_validator regression: fail");
        end
        $finish;
    end

endmodule
